### src/assert_macros.svh
// Assertion macros used by the checker file of the mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mixer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mixer assertion failed");

`endif

### src/adm_pkg.sv
// Shared types, widths and codes of the audio ducking mixer.
package adm_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 16;
  localparam int TIMER_BITS  = 20;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_W      = GAIN_BITS + 1;   // holds unity (32768)
  localparam int GAIN_FRAC   = 15;
  localparam int COUNT_BITS  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (TIMER_BITS > GAIN_BITS) ? TIMER_BITS : GAIN_BITS;

  // Mix datapath widths
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ACC_W  = SUM_W + GAIN_W + 1;
  localparam int FRAC_W = 2 * GAIN_FRAC;
  localparam int QUO_W  = ACC_W - FRAC_W;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(32768);

  // Reset values of the registers
  localparam logic [GAIN_W-1:0]     MASTER_RST  = GAIN_W'(26214);
  localparam logic [GAIN_W-1:0]     DUCK_RST    = GAIN_W'(3277);
  localparam logic [GAIN_W-1:0]     STEP_RST    = GAIN_W'(14);
  localparam logic [TIMER_BITS-1:0] TIMEOUT_RST = TIMER_BITS'(72000);

  typedef enum logic [1:0] {
    ST_MUSIC     = 2'd0,
    ST_DUCKING   = 2'd1,
    ST_RADIO     = 2'd2,
    ST_UNDUCKING = 2'd3
  } duck_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER  = 3'd0,
    CFG_DUCK    = 3'd1,
    CFG_STEP_UP = 3'd2,
    CFG_STEP_DN = 3'd3,
    CFG_TIMEOUT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_MUL_A,
    C_MUL_B,
    C_OUT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic mul_a;
    logic mul_b;
    logic load_out;
  } adm_cmd_t;

endpackage

### src/adm_ctrl.sv
// Controller state machine of the mixer: sequences one word through the datapath.
module adm_ctrl
  import adm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output adm_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = C_MUL_A;
        end
      end
      C_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = C_MUL_B;
      end
      C_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = C_OUT;
      end
      C_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = C_IDLE;
        end
      end
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/adm_datapath.sv
// Datapath of the mixer: config registers, duck state, gain ramp, timer and mix.
module adm_datapath
  import adm_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  adm_cmd_t                      cmd_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          action_i,
  input  logic signed [SAMPLE_BITS-1:0] phone_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] radio_sample_i,
  input  logic                          radio_source_i,
  input  logic                          radio_on_i,
  output logic signed [SAMPLE_BITS-1:0] mixed_sample_o,
  output logic [1:0]                    mixer_state_o,
  output logic [GAIN_BITS-1:0]          phone_gain_now_o,
  output logic [COUNT_BITS-1:0]         ducks_so_far_o
);

  localparam logic signed [QUO_W-1:0] Q_MAX = QUO_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QUO_W-1:0] Q_MIN = ~Q_MAX;
  localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'((1 << FRAC_W) - 1);

  // Config registers, kept already clamped
  logic [GAIN_W-1:0]     master_q, duck_q, step_up_q, step_dn_q;
  logic [TIMER_BITS-1:0] limit_q;
  logic [GAIN_BITS-1:0]  cfg_gain;
  logic [GAIN_W-1:0]     cfg_sat, cfg_step;
  logic [TIMER_BITS-1:0] cfg_timer;

  // Block state
  duck_state_e           st_q, st_d;
  logic [GAIN_W-1:0]     gain_q, gain_d, tgt_q, tgt_d;
  logic                  bt_q, bt_d, wired_q, wired_d, run_q, run_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [COUNT_BITS-1:0] ducks_q, ducks_d;
  logic                  was_on, now_on;

  // Captured word and mix pipeline
  logic                          action_q;
  logic signed [SAMPLE_BITS-1:0] phone_q, radio_q;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS+GAIN_FRAC-1:0] radio_sh;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [ACC_W-1:0]       acc_q, biased;
  logic signed [QUO_W-1:0]       quo;
  logic signed [SAMPLE_BITS-1:0] sat;

  // Clamp incoming config values
  assign cfg_gain  = cfg_data_i[GAIN_BITS-1:0];
  assign cfg_sat   = ({1'b0, cfg_gain} > UNITY) ? UNITY : {1'b0, cfg_gain};
  assign cfg_step  = (cfg_gain == '0) ? GAIN_W'(1) : cfg_sat;
  assign cfg_timer = (cfg_data_i[TIMER_BITS-1:0] == '0) ? TIMER_BITS'(1)
                                                        : cfg_data_i[TIMER_BITS-1:0];

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q  <= MASTER_RST;
      duck_q    <= DUCK_RST;
      step_up_q <= STEP_RST;
      step_dn_q <= STEP_RST;
      limit_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MASTER:  master_q  <= cfg_sat;
        CFG_DUCK:    duck_q    <= cfg_sat;
        CFG_STEP_UP: step_up_q <= cfg_step;
        CFG_STEP_DN: step_dn_q <= cfg_step;
        CFG_TIMEOUT: limit_q   <= cfg_timer;
        default: ;
      endcase
    end
  end

  // Timer tick, gain step and activity events for the word being taken
  always_comb begin
    st_d    = st_q;
    gain_d  = gain_q;
    tgt_d   = tgt_q;
    bt_d    = bt_q;
    wired_d = wired_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    ducks_d = ducks_q;
    cnt_inc = cnt_q + TIMER_BITS'(1);
    was_on  = bt_q | wired_q;
    now_on  = was_on;
    if (!action_i) begin
      // advance the silence timer
      if (run_q) begin
        if (cnt_inc >= limit_q) begin
          run_d = 1'b0;
          cnt_d = '0;
          if (st_q == ST_RADIO) begin
            st_d  = ST_UNDUCKING;
            tgt_d = UNITY;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      // move the gain one step toward the target
      if (gain_q < tgt_d) begin
        gain_d = ((tgt_d - gain_q) <= step_up_q) ? tgt_d : gain_q + step_up_q;
      end else if (gain_q > tgt_d) begin
        gain_d = ((gain_q - tgt_d) <= step_dn_q) ? tgt_d : gain_q - step_dn_q;
      end
      if (gain_d == tgt_d) begin
        if (st_d == ST_DUCKING) begin
          st_d = ST_RADIO;
        end else if (st_d == ST_UNDUCKING) begin
          st_d = ST_MUSIC;
        end
      end
    end else begin
      // update activity flags
      if (!radio_source_i) begin
        bt_d = radio_on_i;
      end else begin
        wired_d = radio_on_i;
      end
      now_on = bt_d | wired_d;
      if (!was_on && now_on) begin
        run_d   = 1'b0;
        cnt_d   = '0;
        st_d    = ST_DUCKING;
        tgt_d   = duck_q;
        ducks_d = ducks_q + COUNT_BITS'(1);
      end else if (was_on && !now_on) begin
        run_d = 1'b1;
        cnt_d = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_MUSIC;
      gain_q  <= UNITY;
      tgt_q   <= UNITY;
      bt_q    <= 1'b0;
      wired_q <= 1'b0;
      run_q   <= 1'b0;
      cnt_q   <= '0;
      ducks_q <= '0;
    end else if (cmd_i.take) begin
      st_q    <= st_d;
      gain_q  <= gain_d;
      tgt_q   <= tgt_d;
      bt_q    <= bt_d;
      wired_q <= wired_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      ducks_q <= ducks_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      action_q <= action_i;
      phone_q  <= phone_sample_i;
      radio_q  <= radio_sample_i;
    end
  end

  // Phone times gain plus radio at unity
  assign prod     = phone_q * $signed({1'b0, gain_q});
  assign radio_sh = {radio_q, {GAIN_FRAC{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      sum_q <= SUM_W'(prod) + SUM_W'(radio_sh);
    end
  end

  // Times master gain
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_b) begin
      acc_q <= sum_q * $signed({1'b0, master_q});
    end
  end

  // Truncate toward zero and saturate
  assign biased = acc_q + (acc_q[ACC_W-1] ? BIAS : '0);
  assign quo    = biased[ACC_W-1:FRAC_W];
  always_comb begin
    if (quo > Q_MAX) begin
      sat = Q_MAX[SAMPLE_BITS-1:0];
    end else if (quo < Q_MIN) begin
      sat = Q_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat = quo[SAMPLE_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mixed_sample_o   <= action_q ? '0 : sat;
      mixer_state_o    <= st_q;
      phone_gain_now_o <= gain_q[GAIN_BITS-1:0];
      ducks_so_far_o   <= ducks_q;
    end
  end

endmodule

### src/audio_duck_mixer.sv
// Top level of the audio ducking mixer: controller plus datapath.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_ready_o    action, phone/radio samples, source, on
//   output   out        out_valid_o / out_ready_i  mixed sample, state, gain, duck count
//   config   in         cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// Each word passes through the accept step (timer, gain step and events), two multiply
// stages (phone times gain, then times master) and the saturating output load.
// The next word is taken while the previous result waits in the output register.
// A stalled output holds the result stage and so blocks the next acceptance.
// Reset restores the config and mixer state registers to their defaults; the
// pipeline and output registers are not reset, and there is no clearing pass.
module audio_duck_mixer
  import adm_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [SAMPLE_BITS-1:0] phone_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] radio_sample_i,
  input  logic                          radio_source_i,
  input  logic                          radio_on_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mixed_sample_o,
  output logic [1:0]                    mixer_state_o,
  output logic [GAIN_BITS-1:0]          phone_gain_now_o,
  output logic [COUNT_BITS-1:0]         ducks_so_far_o
);

  adm_cmd_t cmd;

  // Sequencer
  adm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  adm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .phone_sample_i   (phone_sample_i),
    .radio_sample_i   (radio_sample_i),
    .radio_source_i   (radio_source_i),
    .radio_on_i       (radio_on_i),
    .mixed_sample_o   (mixed_sample_o),
    .mixer_state_o    (mixer_state_o),
    .phone_gain_now_o (phone_gain_now_o),
    .ducks_so_far_o   (ducks_so_far_o)
  );

endmodule

### src/adm_checker.sv
// Port-level checker of the mixer and its bind to the top level.
`include "assert_macros.svh"

module adm_port_checks
  import adm_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [CFG_IDX_W-1:0]          cfg_index_i,
  input logic [CFG_DATA_W-1:0]         cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          action_i,
  input logic signed [SAMPLE_BITS-1:0] phone_sample_i,
  input logic signed [SAMPLE_BITS-1:0] radio_sample_i,
  input logic                          radio_source_i,
  input logic                          radio_on_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] mixed_sample_o,
  input logic [1:0]                    mixer_state_o,
  input logic [GAIN_BITS-1:0]          phone_gain_now_o,
  input logic [COUNT_BITS-1:0]         ducks_so_far_o
);

  // A stalled output word holds
  `ADM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(mixed_sample_o) && $stable(ducks_so_far_o))

  // A word is worked on alone: no acceptance in the cycle after one
  `ADM_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A new result comes only from a busy sequencer
  `ADM_ASSERT_IMP(a_load_when_busy, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

  // In music the phone plays at unity
  `ADM_ASSERT_IMP(a_music_unity, clk_i, rst_ni, out_valid_o && mixer_state_o == ST_MUSIC, phone_gain_now_o == UNITY[GAIN_BITS-1:0])

endmodule

bind audio_duck_mixer adm_port_checks u_adm_checker (.*);
